// ----- rtl/core/rsc_pkg.sv -----
// Package for the resizer setup calculator: request/response structs, stage
// payload structs, status codes, limits and the per-axis setup function.
// No dependencies.
`default_nettype none

package rsc_pkg;

    localparam logic [11:0]        MAX_OUT_WIDTH    = 12'd1280;
    localparam logic [11:0]        MAX_NARROW_WIDTH = 12'd640;
    localparam logic [10:0]        COARSE_THRESHOLD = 11'd512;
    localparam logic [10:0]        UNITY_RATIO      = 11'd256;
    localparam logic signed [17:0] MIN_WINDOW       = 18'sd16;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_WIDE   = 2'd1,
        ST_WIDE_VDOWN = 2'd2,
        ST_SMALL_WIN  = 2'd3
    } t_status;

    typedef struct packed {
        logic [11:0] src_width;
        logic [11:0] src_height;
        logic [11:0] dst_width;
        logic [11:0] dst_height;
        logic [10:0] h_ratio;
        logic [10:0] v_ratio;
        logic        pixel_format;
        logic [4:0]  src_addr_low;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [29:0] control_word;
        logic [3:0]  start_pixel;
        logic [14:0] window_width;
        logic [14:0] window_height;
    } t_rsp;

    // After the multiply stage.
    typedef struct packed {
        logic [22:0] h_prod;
        logic [22:0] v_prod;
        logic [11:0] dst_width;
        logic [10:0] h_ratio;
        logic [10:0] v_ratio;
        logic        h_src_lsb;
        logic        v_src_lsb;
        logic        pixel_format;
        logic [4:0]  src_addr_low;
    } t_s1;

    // After the phase and window size stage.
    typedef struct packed {
        logic [2:0]         h_phase;
        logic [2:0]         v_phase;
        logic signed [17:0] h_size;
        logic signed [17:0] v_size;
        logic [11:0]        dst_width;
        logic [10:0]        h_ratio;
        logic [10:0]        v_ratio;
        logic               pixel_format;
        logic [4:0]         src_addr_low;
    } t_s2;

    typedef struct packed {
        logic [2:0]         phase;
        logic signed [17:0] size;
    } t_axis;

    // Start phase and window size of one axis from the product dst * ratio.
    // Only the low bit of the source size matters to the phase, since the
    // phase keeps the low two or three bits of a difference of multiples.
    function automatic t_axis axis_setup(input logic [22:0] prod,
                                         input logic [10:0] ratio,
                                         input logic        src_lsb,
                                         input logic        vertical);
        t_axis              res;
        logic [1:0]         ph2;
        logic signed [25:0] sum;
        logic signed [17:0] base;
        if (ratio > COARSE_THRESHOLD) begin
            ph2 = {src_lsb, 1'b0} - prod[8:7] + 2'd2;
            res.phase = {1'b0, ph2};
            sum = $signed({3'b0, prod}) - $signed({15'b0, ratio})
                + $signed({17'b0, res.phase, 6'b0}) + 26'sd32;
            base = 18'(sum >>> 8);
            res.size = base + 18'sd7;
        end else begin
            ph2 = 2'b00;
            res.phase = {src_lsb, 2'b00} - prod[8:6];
            sum = $signed({3'b0, prod}) - $signed({15'b0, ratio})
                + $signed({18'b0, res.phase, 5'b0}) + 26'sd16;
            base = 18'(sum >>> 8);
            res.size = base + (vertical ? 18'sd4 : 18'sd7);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rsc_mul_stage.sv -----
// First pipeline stage: the two size-by-ratio products.
// Depends on rsc_pkg.
`default_nettype none

module rsc_mul_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  rsc_pkg::t_req     i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rsc_pkg::t_s1      o_data,
    input  wire               i_ready
);
    import rsc_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.h_prod       = 23'(i_data.dst_width) * 23'(i_data.h_ratio);
        n_data.v_prod       = 23'(i_data.dst_height) * 23'(i_data.v_ratio);
        n_data.dst_width    = i_data.dst_width;
        n_data.h_ratio      = i_data.h_ratio;
        n_data.v_ratio      = i_data.v_ratio;
        n_data.h_src_lsb    = i_data.src_width[0];
        n_data.v_src_lsb    = i_data.src_height[0];
        n_data.pixel_format = i_data.pixel_format;
        n_data.src_addr_low = i_data.src_addr_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/rsc_size_stage.sv -----
// Second pipeline stage: start phase and input window size of both axes.
// Depends on rsc_pkg (axis_setup).
`default_nettype none

module rsc_size_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  rsc_pkg::t_s1      i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rsc_pkg::t_s2      o_data,
    input  wire               i_ready
);
    import rsc_pkg::*;

    logic  r_valid;
    t_s2   r_data;
    t_s2   n_data;
    t_axis h_axis;
    t_axis v_axis;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        h_axis = axis_setup(i_data.h_prod, i_data.h_ratio, i_data.h_src_lsb, 1'b0);
        v_axis = axis_setup(i_data.v_prod, i_data.v_ratio, i_data.v_src_lsb, 1'b1);
        n_data.h_phase      = h_axis.phase;
        n_data.v_phase      = v_axis.phase;
        n_data.h_size       = h_axis.size;
        n_data.v_size       = v_axis.size;
        n_data.dst_width    = i_data.dst_width;
        n_data.h_ratio      = i_data.h_ratio;
        n_data.v_ratio      = i_data.v_ratio;
        n_data.pixel_format = i_data.pixel_format;
        n_data.src_addr_low = i_data.src_addr_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/rsc_pack_stage.sv -----
// Third pipeline stage: error checks, control word packing and the output
// register that faces the downstream receiver. Depends on rsc_pkg.
`default_nettype none

module rsc_pack_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  rsc_pkg::t_s2      i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rsc_pkg::t_rsp     o_data,
    input  wire               i_ready
);
    import rsc_pkg::*;

    logic r_valid;
    t_rsp r_data;
    t_rsp n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = '0;
        priority if (i_data.dst_width > MAX_OUT_WIDTH) begin
            n_data.status = ST_TOO_WIDE;
        end else if (i_data.v_ratio > COARSE_THRESHOLD
                     && i_data.dst_width > MAX_NARROW_WIDTH) begin
            n_data.status = ST_WIDE_VDOWN;
        end else if (i_data.h_size < MIN_WINDOW || i_data.v_size < MIN_WINDOW) begin
            n_data.status = ST_SMALL_WIN;
        end else begin
            n_data.status        = ST_OK;
            n_data.control_word  = {i_data.h_ratio < UNITY_RATIO, 1'b1,
                                    i_data.pixel_format, 1'b0,
                                    i_data.v_phase, i_data.h_phase,
                                    i_data.v_ratio[9:0] - 10'd1,
                                    i_data.h_ratio[9:0] - 10'd1};
            n_data.start_pixel   = i_data.src_addr_low[4:1];
            n_data.window_width  = i_data.h_size[14:0];
            n_data.window_height = i_data.v_size[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/resizer_setup_calculator.sv -----
// Resizer setup calculator, top level. Uses rsc_pkg and the three stage
// modules rsc_mul_stage, rsc_size_stage and rsc_pack_stage.
//
// A request on i_req carries one resize job: source and destination sizes,
// both ratios, the pixel format and the low source address bits. It is taken
// at a rising edge where i_valid is high and o_stall is low. Each request
// yields exactly one response on o_rsp, handed over at an edge where o_valid
// is high and i_stall is low: a status code, the packed control word, the
// start pixel and the input window width and height. On any error status the
// other response fields are zero.
//
// The block is a three-stage pipeline: the products of destination size and
// ratio, then the start phases and window sizes, then the error checks and
// packing into the output register. A request passes through the stage
// registers in that order; its response can be taken once it reaches the
// output register. One request per cycle is taken in steady state while
// the receiver does not stall. The block keeps no state between jobs.
//
// The synchronous active-low reset empties all stages; o_valid is low after
// it. When the receiver raises i_stall, the response holds steady and each
// stage holds as soon as the stage after it is full, so o_stall rises only
// once all three stages are occupied; nothing is dropped or duplicated.
`default_nettype none

module resizer_setup_calculator (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  rsc_pkg::t_req     i_req,
    output logic              o_stall,
    output logic              o_valid,
    output rsc_pkg::t_rsp     o_rsp,
    input  wire               i_stall
);
    import rsc_pkg::*;

    // Ready travels backward and combines per stage, so a bubble anywhere in
    // the pipe can be filled even while the output is stalled.
    logic s1_ready;
    logic s1_valid;
    t_s1  s1_data;
    logic s2_ready;
    logic s2_valid;
    t_s2  s2_data;
    logic s3_ready;

    assign o_stall = !s1_ready;

    rsc_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_req),
        .o_ready (s1_ready),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_ready (s2_ready)
    );

    rsc_size_stage u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_ready (s2_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_ready (s3_ready)
    );

    // The last stage's register is the output register; the response stays
    // put for as long as the receiver stalls.
    rsc_pack_stage u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_ready (s3_ready),
        .o_valid (o_valid),
        .o_data  (o_rsp),
        .i_ready (!i_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rsc_checker.sv -----
// Port-level checker for the resizer setup calculator, bound to the top.
// Depends on rsc_pkg.
`default_nettype none

module rsc_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               o_stall,
    input  wire               o_valid,
    input  rsc_pkg::t_rsp     o_rsp,
    input  wire               i_stall
);
    import rsc_pkg::*;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

    // Any error response carries no settings.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |->
        (o_rsp.control_word == '0 && o_rsp.start_pixel == '0
         && o_rsp.window_width == '0 && o_rsp.window_height == '0))
        else $error("error response with nonzero fields");

    // A good response has the enable bit set and windows of at least 16.
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_OK) |->
        (o_rsp.control_word[28] && o_rsp.control_word[26] == 1'b0
         && o_rsp.window_width >= 15'd16 && o_rsp.window_height >= 15'd16))
        else $error("good response with bad control word or window");

    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)))
        else $error("response dropped or changed under stall");

    // The input is only held off while a response waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled response");

endmodule

bind resizer_setup_calculator rsc_checker u_rsc_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for resizer_setup_calculator: directed and random resize jobs checked
// against a behavioral predictor of the setup arithmetic.
// Depends on rsc_pkg and the resizer_setup_calculator RTL.

module tb_top;
    import rsc_pkg::*;

    // Clock, reset and the two handshake channels. Every input of the block
    // starts from a known value.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_req i_req   = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    // Expected responses, oldest first, one per accepted request.
    t_rsp expected_setups[$];

    int jobs_sent;
    int responses_checked;
    int mismatches;
    int status_seen[4];

    // Idle rates in percent for the sending and the receiving side.
    int send_idle_pct;
    int recv_idle_pct;

    // A long receiver hold-off is armed by a test and counted down by the
    // receiver process itself.
    bit hold_armed;
    int hold_len;

    resizer_setup_calculator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_req  (i_req),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_rsp  (o_rsp),
        .i_stall(i_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Window size and start phase of one axis. A ratio above the coarse
    // threshold selects the 4-phase/7-tap filter, any other ratio the
    // 8-phase filter, 4-tap (7-tap horizontally). The arithmetic is exact
    // and signed: with zero destination sizes the sums go negative, and the
    // arithmetic shift then rounds toward minus infinity, as the hardware must.
    function automatic void axis_window(input longint src, input longint dst,
                                        input longint ratio, input bit vertical,
                                        output int phase, output longint win);
        longint diff;
        if (ratio > longint'(COARSE_THRESHOLD)) begin
            diff  = (src + 8) * 2 - ((dst * ratio * 2) >>> 8);
            phase = int'((diff + 2) & 3);
            win   = ((64 * phase + (dst - 1) * ratio + 32) >>> 8) + 7;
        end else begin
            diff  = (src + 8) * 4 - ((dst * ratio * 4) >>> 8);
            phase = int'(diff & 7);
            win   = ((32 * phase + (dst - 1) * ratio + 16) >>> 8) + (vertical ? 4 : 7);
        end
    endfunction

    // Full setup of one job. The error checks run in order of precedence,
    // and any error leaves every other field at zero.
    function automatic t_rsp compute_setup(input t_req job);
        t_rsp   rsp;
        int     h_phase;
        int     v_phase;
        longint h_win;
        longint v_win;
        rsp = '0;
        if (job.dst_width > MAX_OUT_WIDTH) begin
            rsp.status = ST_TOO_WIDE;
        end else if (job.v_ratio > COARSE_THRESHOLD && job.dst_width > MAX_NARROW_WIDTH) begin
            rsp.status = ST_WIDE_VDOWN;
        end else begin
            axis_window(job.src_width, job.dst_width, job.h_ratio, 1'b0, h_phase, h_win);
            axis_window(job.src_height, job.dst_height, job.v_ratio, 1'b1, v_phase, v_win);
            if (h_win < 16 || v_win < 16) begin
                rsp.status = ST_SMALL_WIN;
            end else begin
                // Ratios outside the field range simply wrap in the 10-bit
                // ratio-minus-one fields.
                rsp.status       = ST_OK;
                rsp.control_word = {job.h_ratio < UNITY_RATIO, 1'b1, job.pixel_format, 1'b0,
                                    3'(v_phase), 3'(h_phase),
                                    10'(job.v_ratio - 11'd1), 10'(job.h_ratio - 11'd1)};
                rsp.start_pixel   = job.src_addr_low[4:1];
                rsp.window_width  = h_win[14:0];
                rsp.window_height = v_win[14:0];
            end
        end
        return rsp;
    endfunction

    function automatic t_req make_job(input int sw, input int sh, input int dw, input int dh,
                                      input int hr, input int vr, input int fmt,
                                      input int addr);
        t_req job;
        job.src_width    = 12'(sw);
        job.src_height   = 12'(sh);
        job.dst_width    = 12'(dw);
        job.dst_height   = 12'(dh);
        job.h_ratio      = 11'(hr);
        job.v_ratio      = 11'(vr);
        job.pixel_format = 1'(fmt);
        job.src_addr_low = 5'(addr);
        return job;
    endfunction

    // Random job. Half are well-formed: ratios in the usual range and a
    // source size close to what the ratio implies. Some sit on the error
    // boundaries, some have tiny windows, and the rest are raw bits, which
    // also reaches zero sizes and ratios outside the usual range.
    function automatic t_req random_job();
        logic [95:0] raw;
        int          kind;
        int          sw;
        int          sh;
        int          dw;
        int          dh;
        int          hr;
        int          vr;
        int          widths[6] = '{639, 640, 641, 1279, 1280, 1281};
        int          ratios[6] = '{255, 256, 511, 512, 513, 1024};
        raw  = {$urandom, $urandom, $urandom};
        kind = $urandom_range(99);
        if (kind < 15) begin
            return raw[75:0];
        end
        hr = $urandom_range(64, 1024);
        vr = $urandom_range(64, 1024);
        if (kind < 65) begin
            dw = $urandom_range(1, 1280);
            dh = $urandom_range(1, 2000);
            if (vr > 512 && dw > 640 && $urandom_range(9) != 0) begin
                dw = $urandom_range(1, 640);
            end
        end else if (kind < 82) begin
            dw = widths[$urandom_range(5)];
            dh = $urandom_range(1, 1080);
            hr = ratios[$urandom_range(5)];
            vr = ratios[$urandom_range(5)];
        end else begin
            dw = $urandom_range(1, 24);
            dh = $urandom_range(1, 24);
            hr = $urandom_range(64, 400);
            vr = $urandom_range(64, 400);
        end
        sw = ((dw * hr) >> 8) + $urandom_range(16) - 8;
        sh = ((dh * vr) >> 8) + $urandom_range(16) - 8;
        sw = (sw < 0) ? 0 : (sw > 4095) ? 4095 : sw;
        sh = (sh < 0) ? 0 : (sh > 4095) ? 4095 : sh;
        return make_job(sw, sh, dw, dh, hr, vr, $urandom_range(1), $urandom_range(31));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH response %0d %s: got 0x%0h, expected 0x%0h",
                 responses_checked, what, got, want);
    endtask

    // Offers one request, possibly after a random gap, and holds it until the
    // block takes it. The expectation is queued at the accepting edge.
    task automatic send_job(input t_req job);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= job;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        expected_setups.push_back(compute_setup(job));
        jobs_sent++;
    endtask

    // Drops valid and waits for every expected response, then keeps the clock
    // running so that a stray extra response would still be seen.
    task automatic wait_for_responses();
        int waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (expected_setups.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_setups.size() != 0) begin
            report_mismatch("responses still missing at end", 0, expected_setups.size());
        end
    endtask

    // Receiver side: random stalls, or a long counted hold-off when armed.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Every handed-over response is compared field by field with the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_setups.size() == 0) begin
                report_mismatch("response with no job pending",
                                longint'(o_rsp.control_word), 0);
            end else begin
                want = expected_setups.pop_front();
                if (o_rsp.status !== want.status) begin
                    report_mismatch("status", o_rsp.status, want.status);
                end
                if (o_rsp.control_word !== want.control_word) begin
                    report_mismatch("control_word", o_rsp.control_word, want.control_word);
                end
                if (o_rsp.start_pixel !== want.start_pixel) begin
                    report_mismatch("start_pixel", o_rsp.start_pixel, want.start_pixel);
                end
                if (o_rsp.window_width !== want.window_width) begin
                    report_mismatch("window_width", o_rsp.window_width, want.window_width);
                end
                if (o_rsp.window_height !== want.window_height) begin
                    report_mismatch("window_height", o_rsp.window_height,
                                    want.window_height);
                end
                status_seen[want.status]++;
            end
            responses_checked++;
        end
    end

    // Each error code and its precedence, plus the boundaries right beside
    // each error.
    task automatic test_status_codes();
        send_job(make_job(1300, 720, 1281, 720, 256, 256, 0, 0));    // one pixel too wide
        send_job(make_job(4095, 100, 4095, 4, 1024, 1024, 1, 0));    // too wide beats the rest
        send_job(make_job(1280, 720, 1280, 720, 256, 256, 0, 2));    // widest legal output
        send_job(make_job(1282, 1400, 641, 480, 512, 513, 0, 0));   // wide with vertical downscale
        send_job(make_job(1280, 1400, 640, 480, 512, 513, 1, 4));   // just narrow enough
        send_job(make_job(1282, 960, 641, 480, 512, 512, 0, 6));    // ratio not above threshold
        send_job(make_job(10, 10, 1, 1, 64, 64, 0, 0));             // tiny window
        send_job(make_job(0, 0, 0, 0, 256, 256, 0, 0));             // zero sizes, negative window
        send_job(make_job(100, 1, 100, 2, 256, 64, 0, 0));          // only the height too small
    endtask

    // Extremes of every field: all zeros, all ones, ratios that wrap in the
    // control word, odd and even address bits and both formats.
    task automatic test_field_extremes();
        send_job(make_job(0, 0, 0, 0, 0, 0, 0, 0));
        send_job(make_job(4095, 4095, 4095, 4095, 2047, 2047, 1, 31));
        send_job(make_job(4095, 4095, 640, 4095, 2047, 2047, 1, 31)); // largest window height
        send_job(make_job(200, 200, 200, 200, 0, 0, 0, 0));          // zero ratio
        send_job(make_job(400, 600, 100, 100, 1025, 1536, 1, 1));    // ratios past 1024
        send_job(make_job(0, 0, 300, 300, 256, 256, 0, 30));         // zero source
        send_job(make_job(318, 300, 320, 300, 255, 256, 1, 17));     // bilinear bit just set
    endtask

    // Both filter modes on each axis, around the threshold and at the ends
    // of the usual ratio range, with even and odd source sizes.
    task automatic test_scaling_modes();
        send_job(make_job(640, 480, 320, 240, 512, 512, 0, 0));
        send_job(make_job(641, 481, 320, 240, 513, 513, 1, 3));
        send_job(make_job(101, 1023, 400, 250, 64, 1024, 0, 9));
        send_job(make_job(1023, 33, 250, 400, 1024, 64, 1, 12));
        send_job(make_job(4095, 1, 640, 64, 700, 100, 0, 21));
    endtask

    task automatic test_random_jobs(input int count);
        repeat (count) send_job(random_job());
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the pipeline fills up and the block stalls its input.
    task automatic test_output_hold_off();
        i_valid <= 1'b0;
        @(negedge i_clk);
        hold_len   = 80;
        hold_armed = 1'b1;
        @(posedge i_clk);
        repeat (40) send_job(random_job());
    endtask

    initial begin
        hold_armed    = 1'b0;
        hold_len      = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles often less than the receiver first, then the other way
        // round, then neither side idles.
        send_idle_pct = 33;
        recv_idle_pct = 72;
        test_status_codes();
        test_field_extremes();
        test_scaling_modes();
        test_random_jobs(520);

        send_idle_pct = 72;
        recv_idle_pct = 33;
        test_random_jobs(520);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_jobs(500);
        test_output_hold_off();
        wait_for_responses();

        $display("Sent %0d resize jobs, checked %0d responses.", jobs_sent, responses_checked);
        $display("Outcomes: %0d ok, %0d too wide, %0d wide with vertical downscale, %0d small window.",
                 status_seen[ST_OK], status_seen[ST_TOO_WIDE], status_seen[ST_WIDE_VDOWN],
                 status_seen[ST_SMALL_WIN]);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Well beyond the slowest correct run.
    initial begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- resizer_setup_calculator.f -----
rtl/core/rsc_pkg.sv
rtl/core/rsc_mul_stage.sv
rtl/core/rsc_size_stage.sv
rtl/core/rsc_pack_stage.sv
rtl/core/resizer_setup_calculator.sv
rtl/core/rsc_checker.sv
test/tb_top.sv
